// File: rtl/dual_sync_frame_receiver_defines.svh
// Assertion macros used by the frame receiver top level.
`ifndef DUAL_SYNC_FRAME_RECEIVER_DEFINES_SVH
`define DUAL_SYNC_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DSFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dsfr_pkg.sv
// Types and constants for the dual sync frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package dsfr_pkg;

  localparam int MAX_FRAME_BYTES = 128;
  localparam int RESPONSE_BYTES  = 24;

  localparam int CNT_MAX = (MAX_FRAME_BYTES > RESPONSE_BYTES) ? MAX_FRAME_BYTES
                                                              : RESPONSE_BYTES;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam logic [7:0] SYNC_RESP_A = 8'hAA;
  localparam logic [7:0] SYNC_RESP_B = 8'h55;
  localparam logic [7:0] SYNC_DATA_A = 8'hA5;
  localparam logic [7:0] SYNC_DATA_B = 8'h5A;

  localparam logic [16:0] DATA_LEN_EXTRA = 17'd8;
  // Completion needs the whole header (sync excluded) before the length counts.
  localparam int HEADER_BYTES = 6;

  localparam int CMD_LO_IDX = 2;
  localparam int CMD_HI_IDX = 3;
  localparam int LEN_LO_IDX = 4;
  localparam int LEN_HI_IDX = 5;

  localparam logic KIND_RESP = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT      = 3'd0,
    PH_RESP_SYNC = 3'd1,
    PH_RESP_BODY = 3'd2,
    PH_DATA_SYNC = 3'd3,
    PH_DATA_BODY = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ABORT = 2'd2
  } event_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_kind;
    logic [6:0]  byte_index;
    event_t      event_code;
    logic [15:0] frame_command;
    logic [15:0] frame_length;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/dsfr_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
`timescale 1ns / 1ps
`default_nettype none
interface dsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dsfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        frame_kind;
  logic [6:0]  byte_index;
  logic [1:0]  event_code;
  logic [15:0] frame_command;
  logic [15:0] frame_length;

  modport source (output valid, output data_byte, output frame_kind, output byte_index,
                  output event_code, output frame_command, output frame_length,
                  input ready);
  modport sink (input valid, input data_byte, input frame_kind, input byte_index,
                input event_code, input frame_command, input frame_length,
                output ready);
endinterface
`default_nettype wire

// File: rtl/dual_sync_frame_receiver.sv
// Top level of the dual sync frame receiver.
// Accepts one received byte per cycle while results are accepted. Bytes pass an
// input register, then the sync/body parser, then a result register. A result
// is offered from the result register, which loads when the parser takes its
// byte from the input register. While a result waits unaccepted the parser
// stalls: the input register takes at most one more byte and the input then
// holds ready low. AA 55 opens a response frame of RESPONSE_BYTES body bytes;
// A5 5A opens a data frame that completes when the body count equals the
// length word (body bytes 4 and 5) plus 8, or aborts at MAX_FRAME_BYTES. Every
// body byte gives one result; sync and hunted bytes give none. Command and
// length are reported only on the completing byte.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_sync_frame_receiver_defines.svh"
module dual_sync_frame_receiver
  import dsfr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  dsfr_in_if.sink     in_if,
  dsfr_out_if.source  out_if
);

  logic       byte_vld;
  logic [7:0] byte_q;
  logic       can_load;
  logic       take;
  logic       res_vld;
  result_t    res;
  result_t    out_res;

  assign take = byte_vld && can_load;

  dsfr_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_byte  (in_if.rx_byte),
    .in_ready (in_if.ready),
    .take     (take),
    .byte_vld (byte_vld),
    .byte_q   (byte_q)
  );

  dsfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (byte_q),
    .res_vld (res_vld),
    .res     (res)
  );

  dsfr_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .res_vld   (res_vld),
    .res       (res),
    .out_ready (out_if.ready),
    .can_load  (can_load),
    .out_valid (out_if.valid),
    .out_res   (out_res)
  );

  assign out_if.data_byte     = out_res.data_byte;
  assign out_if.frame_kind    = out_res.frame_kind;
  assign out_if.byte_index    = out_res.byte_index;
  assign out_if.event_code    = out_res.event_code;
  assign out_if.frame_command = out_res.frame_command;
  assign out_if.frame_length  = out_res.frame_length;

  `DSFR_ASSERT_NEXT(a_in_loads, in_if.valid && in_if.ready, byte_vld, "accepted byte not held")
  `DSFR_ASSERT_NOW(a_no_overrun, out_if.valid && !out_if.ready, !take, "result overwritten")
  `DSFR_ASSERT_NOW(a_words_only_done,
                   out_if.valid && out_res.event_code != EV_DONE,
                   out_if.frame_command == 16'd0 && out_if.frame_length == 16'd0,
                   "command or length outside completion")
  `DSFR_ASSERT_NOW(a_resp_len,
                   out_if.valid && out_if.frame_kind == KIND_RESP && out_res.event_code == EV_DONE,
                   out_if.byte_index == 7'(RESPONSE_BYTES - 1),
                   "response frame ended at wrong index")

endmodule
`default_nettype wire

// File: rtl/dsfr_in_stage.sv
// Input register holding one received byte until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none
module dsfr_in_stage
  import dsfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  output logic            in_ready,
  input  wire logic       take,
  output logic            byte_vld,
  output logic [7:0]      byte_q
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;

  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  assign byte_vld = vld_r;
  assign byte_q   = byte_r;

endmodule
`default_nettype wire

// File: rtl/dsfr_parser.sv
// Sync hunt and frame body tracking; forms one result per body byte.
`timescale 1ns / 1ps
`default_nettype none
module dsfr_parser
  import dsfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  output logic            res_vld,
  output result_t         res
);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [15:0]        cmd_r, cmd_nxt;
  logic [15:0]        len_r, len_nxt;

  logic [CNT_W-1:0]   received;
  logic [CNT_W+6:0]   idx_wide;
  logic [15:0]        cmd_upd, len_upd;
  logic               done_data, abort_data, done_resp;
  event_t             ev;

  assign received = count_r + CNT_W'(1);
  assign idx_wide = (CNT_W + 7)'(count_r);

  always_comb begin
    cmd_upd = cmd_r;
    len_upd = len_r;
    if (count_r == CNT_W'(CMD_LO_IDX)) cmd_upd[7:0]  = rx_byte;
    if (count_r == CNT_W'(CMD_HI_IDX)) cmd_upd[15:8] = rx_byte;
    if (count_r == CNT_W'(LEN_LO_IDX)) len_upd[7:0]  = rx_byte;
    if (count_r == CNT_W'(LEN_HI_IDX)) len_upd[15:8] = rx_byte;
  end

  assign done_resp  = received >= CNT_W'(RESPONSE_BYTES);
  assign done_data  = (received > CNT_W'(HEADER_BYTES)) &&
                      (({1'b0, len_upd} + DATA_LEN_EXTRA) == 17'(received));
  assign abort_data = received >= CNT_W'(MAX_FRAME_BYTES);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    res_vld   = 1'b0;
    ev        = EV_BYTE;
    res.frame_kind = KIND_RESP;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == SYNC_RESP_A) begin
          phase_nxt = PH_RESP_SYNC;
        end else if (rx_byte == SYNC_DATA_A) begin
          phase_nxt = PH_DATA_SYNC;
        end
      end
      PH_RESP_SYNC, PH_DATA_SYNC: begin
        // Open the frame on the matching second byte, otherwise drop back to hunt.
        if ((phase_r == PH_RESP_SYNC && rx_byte == SYNC_RESP_B) ||
            (phase_r == PH_DATA_SYNC && rx_byte == SYNC_DATA_B)) begin
          phase_nxt = (phase_r == PH_RESP_SYNC) ? PH_RESP_BODY : PH_DATA_BODY;
          count_nxt = '0;
          cmd_nxt   = '0;
          len_nxt   = '0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_RESP_BODY, PH_DATA_BODY: begin
        res_vld = 1'b1;
        cmd_nxt = cmd_upd;
        len_nxt = len_upd;
        if (phase_r == PH_RESP_BODY) begin
          res.frame_kind = KIND_RESP;
          if (done_resp) ev = EV_DONE;
        end else begin
          res.frame_kind = KIND_DATA;
          if (done_data) begin
            ev = EV_DONE;
          end else if (abort_data) begin
            ev = EV_ABORT;
          end
        end
        if (ev == EV_BYTE) begin
          count_nxt = received;
        end else begin
          phase_nxt = PH_HUNT;
          count_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        count_nxt = '0;
      end
    endcase
    res.data_byte     = rx_byte;
    res.byte_index    = idx_wide[6:0];
    res.event_code    = ev;
    res.frame_command = (ev == EV_DONE) ? cmd_upd : 16'd0;
    res.frame_length  = (ev == EV_DONE) ? len_upd : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dsfr_out_stage.sv
// Result register driving the output channel.
`timescale 1ns / 1ps
`default_nettype none
module dsfr_out_stage
  import dsfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     take,
  input  wire logic     res_vld,
  input  wire result_t  res,
  input  wire logic     out_ready,
  output logic          can_load,
  output logic          out_valid,
  output result_t       out_res
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign can_load = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r && !out_ready;
    if (take) begin
      vld_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire
